// ===== rtl/rgba_hs_pkg.sv =====
// ============================================================================
// rgba_hs_pkg - shared types and constants for the half-scale box averager
// Line store geometry, register indexes, channel lane types, geometry struct.
// ============================================================================
package rgba_hs_pkg;

    // Largest supported input width in pixels
    localparam int MAX_WIDTH  = 4096;
    // One line store entry per horizontal pixel pair
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    // Column counter width (holds 0 .. MAX_WIDTH-1)
    localparam int COL_W      = $clog2(MAX_WIDTH);

    // Register field widths
    localparam int FW_W       = 13;
    localparam int FH_W       = 16;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // Register reset values
    localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
    localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

    // Register indexes (paddr[2])
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int NUM_CH = 4;
    localparam int CH_W   = 8;
    localparam int SUM_W  = CH_W + 1;

    typedef logic [NUM_CH-1:0][CH_W-1:0]  t_pix;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] t_pair;

    // Frame geometry seen by the datapath
    typedef struct packed {
        logic [COL_W-1:0] last_col;       // last column of an input row
        logic [COL_W-1:0] used_last_col;  // last column that joins a block
        logic [FH_W-1:0]  last_row;       // last row of an input frame
        logic [FH_W-1:0]  used_last_row;  // last row that joins a block
        logic             restart;        // register write: restart frame
    } t_geom;

endpackage

// ===== rtl/rgba_hs_ram.sv =====
// ============================================================================
// rgba_hs_ram - generic single-port RAM with registered read
// One access per cycle; read data holds until the next read.
// ============================================================================
module rgba_hs_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rgba_hs_cfg.sv =====
// ============================================================================
// rgba_hs_cfg - APB register file for the half-scale box averager
// Holds frame width and height, derives the clamped frame geometry.
// ============================================================================
module rgba_hs_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rgba_hs_pkg::ADDR_W-1:0] paddr,
    input  logic [rgba_hs_pkg::DATA_W-1:0] pwdata,
    output logic [rgba_hs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output rgba_hs_pkg::t_geom         o_geom
);

    logic [rgba_hs_pkg::FW_W-1:0] r_frame_width;
    logic [rgba_hs_pkg::FH_W-1:0] r_frame_height;
    logic                         wr_en;
    logic                         reg_idx;
    logic [rgba_hs_pkg::FW_W-1:0] eff_w;
    logic [rgba_hs_pkg::FW_W-1:0] used_w;
    logic [rgba_hs_pkg::FH_W-1:0] eff_h;
    logic [rgba_hs_pkg::FH_W-1:0] used_h;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= rgba_hs_pkg::WIDTH_RESET;
            r_frame_height <= rgba_hs_pkg::HEIGHT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                rgba_hs_pkg::REG_WIDTH: begin
                    r_frame_width <= pwdata[rgba_hs_pkg::FW_W-1:0];
                end
                rgba_hs_pkg::REG_HEIGHT: begin
                    r_frame_height <= pwdata[rgba_hs_pkg::FH_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rgba_hs_pkg::REG_WIDTH:  prdata = rgba_hs_pkg::DATA_W'(r_frame_width);
            rgba_hs_pkg::REG_HEIGHT: prdata = rgba_hs_pkg::DATA_W'(r_frame_height);
            default:                 prdata = '0;
        endcase
    end

    // Clamp width to [2, MAX_WIDTH], height to at least 2
    always_comb begin
        if (r_frame_width < rgba_hs_pkg::FW_W'(2)) begin
            eff_w = rgba_hs_pkg::FW_W'(2);
        end else if (r_frame_width > rgba_hs_pkg::FW_W'(rgba_hs_pkg::MAX_WIDTH)) begin
            eff_w = rgba_hs_pkg::FW_W'(rgba_hs_pkg::MAX_WIDTH);
        end else begin
            eff_w = r_frame_width;
        end
        if (r_frame_height < rgba_hs_pkg::FH_W'(2)) begin
            eff_h = rgba_hs_pkg::FH_W'(2);
        end else begin
            eff_h = r_frame_height;
        end
        used_w = {eff_w[rgba_hs_pkg::FW_W-1:1], 1'b0};
        used_h = {eff_h[rgba_hs_pkg::FH_W-1:1], 1'b0};
    end

    assign o_geom.last_col      = rgba_hs_pkg::COL_W'(eff_w - rgba_hs_pkg::FW_W'(1));
    assign o_geom.used_last_col = rgba_hs_pkg::COL_W'(used_w - rgba_hs_pkg::FW_W'(1));
    assign o_geom.last_row      = eff_h - rgba_hs_pkg::FH_W'(1);
    assign o_geom.used_last_row = used_h - rgba_hs_pkg::FH_W'(1);
    assign o_geom.restart       = wr_en;

endmodule

// ===== rtl/rgba_hs_line.sv =====
// ============================================================================
// rgba_hs_line - pair sum and line store stage
// Forms horizontal pair sums, stores them on even rows, reads them on odd rows.
// ============================================================================
module rgba_hs_line (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rgba_hs_pkg::t_geom       i_geom,
    input  logic                     i_fire,
    input  rgba_hs_pkg::t_pix        i_pix,
    output logic                     o_emit,
    output logic                     o_last,
    output rgba_hs_pkg::t_pair       o_sum,
    output rgba_hs_pkg::t_pair       o_above
);

    logic [rgba_hs_pkg::COL_W-1:0] r_col;
    logic [rgba_hs_pkg::FH_W-1:0]  r_row;
    rgba_hs_pkg::t_pix             r_partial;
    rgba_hs_pkg::t_pair            pair_sum;
    logic                          in_used;
    logic                          ram_we;
    logic                          ram_re;
    logic [rgba_hs_pkg::LINE_AW-1:0] slot;

    assign in_used = (r_col <= i_geom.used_last_col) && (r_row <= i_geom.used_last_row);
    assign slot    = r_col[rgba_hs_pkg::COL_W-1:1];
    assign ram_we  = i_fire && in_used && r_col[0] && !r_row[0];
    assign ram_re  = i_fire && in_used && r_col[0] && r_row[0];

    always_comb begin
        for (int i = 0; i < rgba_hs_pkg::NUM_CH; i++) begin
            pair_sum[i] = rgba_hs_pkg::SUM_W'(r_partial[i]) + rgba_hs_pkg::SUM_W'(i_pix[i]);
        end
    end

    // Raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_geom.restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_fire) begin
            if (r_col == i_geom.last_col) begin
                r_col <= '0;
                r_row <= (r_row == i_geom.last_row) ? '0 : r_row + rgba_hs_pkg::FH_W'(1);
            end else begin
                r_col <= r_col + rgba_hs_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
        end else if (i_fire && in_used && !r_col[0]) begin
            r_partial <= i_pix;
        end
    end

    rgba_hs_ram #(
        .WIDTH ($bits(rgba_hs_pkg::t_pair)),
        .DEPTH (rgba_hs_pkg::LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (slot),
        .i_wdata (pair_sum),
        .o_rdata (o_above)
    );

    assign o_emit = ram_re;
    assign o_last = (r_row == i_geom.used_last_row) && (r_col == i_geom.used_last_col);
    assign o_sum  = pair_sum;

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= i_geom.last_col)
        else $error("column position beyond row end");
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_geom.restart |=> (r_col == '0) && (r_row == '0))
        else $error("register write did not restart frame");
    a_ram_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("line store read and write in one cycle");
`endif

endmodule

// ===== rtl/rgba_half_scale_box_average.sv =====
// ============================================================================
// rgba_half_scale_box_average - 2x2 box filter downsampler for RGBA8
// Half-size image from a raster-order pixel stream, truncated per-channel mean.
// ============================================================================
// Takes one RGBA8 pixel per clock in raster order while o_in_ready is high
// (low only while stage 1 holds a block and the output stalls) and returns
// the half-size image: each result is (sum of a 2x2 block) >> 2 per channel.
// A block's result passes through the line store read, then the output
// register. Even rows write horizontal pair sums into a 2048 x 36 line store
// (at most one single-port RAM access per transaction); odd rows read them
// back. An odd last column or row is consumed with no result. o_out_frame_end
// flags the last result of a frame. Width (13 bits, clamped to 2..4096) and
// height (16 bits, at least 2) sit at APB byte addresses 0 and 4; any write
// restarts the frame at row 0, column 0. Write them only when the block is idle.
module rgba_half_scale_box_average (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rgba_hs_pkg::ADDR_W-1:0] paddr,
    input  logic [rgba_hs_pkg::DATA_W-1:0] pwdata,
    output logic [rgba_hs_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    // Input pixel channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_pixel_red,
    input  logic [7:0]                     i_pixel_green,
    input  logic [7:0]                     i_pixel_blue,
    input  logic [7:0]                     i_pixel_alpha,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_out_red,
    output logic [7:0]                     o_out_green,
    output logic [7:0]                     o_out_blue,
    output logic [7:0]                     o_out_alpha,
    output logic                           o_out_frame_end
);

    rgba_hs_pkg::t_geom geom;
    rgba_hs_pkg::t_pix  in_pix;
    rgba_hs_pkg::t_pair pair_sum;
    rgba_hs_pkg::t_pair above;
    logic               in_fire;
    logic               emit;
    logic               emit_last;
    logic               out_load;

    // Stage 1: block waiting for its line store read data
    logic               r_s1_valid;
    logic               r_s1_last;
    rgba_hs_pkg::t_pair r_s1_sum;

    // Output register
    logic               r_out_valid;
    logic               r_out_last;
    rgba_hs_pkg::t_pix  r_out_pix;
    rgba_hs_pkg::t_pix  n_out_pix;

    rgba_hs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (geom)
    );

    assign in_pix = {i_pixel_alpha, i_pixel_blue, i_pixel_green, i_pixel_red};

    // Output register takes a new value when empty or being drained.
    // Stage 1 frees up whenever it moves on, so input keeps flowing while a
    // result waits at the output, as long as stage 1 is empty.
    assign out_load   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || out_load;
    assign in_fire    = i_in_valid && o_in_ready;

    rgba_hs_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_fire  (in_fire),
        .i_pix   (in_pix),
        .o_emit  (emit),
        .o_last  (emit_last),
        .o_sum   (pair_sum),
        .o_above (above)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire && emit) begin
            r_s1_valid <= 1'b1;
        end else if (out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_s1_sum  <= pair_sum;
            r_s1_last <= emit_last;
        end
    end

    // Row above plus this row, divided by four
    always_comb begin
        for (int i = 0; i < rgba_hs_pkg::NUM_CH; i++) begin
            n_out_pix[i] = rgba_hs_pkg::CH_W'(
                ((rgba_hs_pkg::SUM_W + 1)'(above[i]) + (rgba_hs_pkg::SUM_W + 1)'(r_s1_sum[i]))
                >> 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out_pix  <= n_out_pix;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_red       = r_out_pix[0];
    assign o_out_green     = r_out_pix[1];
    assign o_out_blue      = r_out_pix[2];
    assign o_out_alpha     = r_out_pix[3];
    assign o_out_frame_end = r_out_last;

`ifndef SYNTHESIS
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_load) |=> r_s1_valid)
        else $error("pending block dropped during output stall");
    a_s1_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_load) |-> !o_in_ready)
        else $error("input accepted while stage 1 is stuck");
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_load) |=> r_out_valid)
        else $error("stage 1 result not moved to output");
`endif

endmodule
